FILE: hw/rtl/ffck_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffck_pkg
// Shared types, codes and constants for the calculator key logic.
// ----------------------------------------------------------------------------
package ffck_pkg;

    localparam int MAX_DIGITS_DEFAULT  = 9;
    localparam int VALUE_WIDTH_DEFAULT = 32;
    localparam int DISPLAY_WIDTH       = 32;

    localparam logic [3:0] DIGIT_MAX = 4'd9;

    localparam logic [1:0] KIND_DIGIT  = 2'd0;
    localparam logic [1:0] KIND_OPER   = 2'd1;
    localparam logic [1:0] KIND_EQUALS = 2'd2;

    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    typedef enum logic
    {
        MODE_MUL = 1'b0,
        MODE_DIV = 1'b1
    } unit_mode_t;

    typedef struct packed
    {
        logic       start;
        unit_mode_t mode;
    } unit_cmd_t;

    function automatic longint pow10(input int n);
        longint r;
        r = 1;
        for (int i = 0; i < n; i++)
        begin
            r = r * 10;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ffck_muldiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffck_muldiv
// Iterative unsigned multiply and restoring divide over one shared adder,
// one bit per cycle.
// ----------------------------------------------------------------------------
module ffck_muldiv #(
    parameter int VALUE_WIDTH = ffck_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ffck_pkg::unit_cmd_t    cmd,
    input  wire logic [VALUE_WIDTH-1:0] op_a,
    input  wire logic [VALUE_WIDTH-1:0] op_b,
    output logic                        done,
    output logic [VALUE_WIDTH-1:0]      result
);
    import ffck_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [CW-1:0] count_reg, count_next;
    unit_mode_t    mode_reg, mode_next;
    logic          done_reg, done_next;

    logic [W-1:0]  shifted;
    logic [W:0]    sum;
    logic          is_mul;

    assign is_mul  = (mode_reg == MODE_MUL);
    assign shifted = {acc_reg[W-2:0], b_reg[W-1]};
    assign sum     = is_mul ? ({1'b0, acc_reg} + {1'b0, a_reg})
                            : ({1'b0, shifted} + {1'b0, ~a_reg} + {{W{1'b0}}, 1'b1});

    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        count_next = count_reg;
        mode_next  = mode_reg;
        done_next  = 1'b0;
        if (cmd.start)
        begin
            a_next     = op_a;
            b_next     = op_b;
            acc_next   = '0;
            mode_next  = cmd.mode;
            count_next = CW'(W);
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - 1'b1;
            done_next  = (count_reg == CW'(1));
            if (is_mul)
            begin
                if (b_reg[0])
                begin
                    acc_next = sum[W-1:0];
                end
                a_next = {a_reg[W-2:0], 1'b0};
                b_next = {1'b0, b_reg[W-1:1]};
            end
            else
            begin
                acc_next = sum[W] ? sum[W-1:0] : shifted;
                b_next   = {b_reg[W-2:0], sum[W]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
            mode_reg  <= MODE_MUL;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
            mode_reg  <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done   = done_reg;
    assign result = is_mul ? acc_reg : b_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/four_function_calculator_keys_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// four_function_calculator_keys_core
// Keypad event sequencer of a four-function calculator.
// ----------------------------------------------------------------------------
// One keypad event is handled at a time; in_stall stays high until its result
// transaction is taken. Each event goes from S_DECODE to S_RESP: a valid
// digit key through S_APPEND, an operator key with nothing to run through
// S_FINISH, equals with an operation to run through S_RUN, and an operator
// key that runs one through S_RUN and S_FINISH. Multiply and a nonzero divide
// also wait in S_WAIT on the bit-serial multiply/divide unit. display_value
// shows the low 32 bits of the entry, zero-extended when VALUE_WIDTH is
// narrower.
// ----------------------------------------------------------------------------
module four_function_calculator_keys_core #(
    parameter int MAX_DIGITS  = ffck_pkg::MAX_DIGITS_DEFAULT,
    parameter int VALUE_WIDTH = ffck_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [3:0]  digit_value,
    input  wire logic [2:0]  operator_code,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic signed [ffck_pkg::DISPLAY_WIDTH-1:0] display_value,
    output logic             accepted,
    output logic             divide_error
);
    import ffck_pkg::*;

    localparam int W = VALUE_WIDTH;
    localparam longint LIMIT = pow10(MAX_DIGITS - 1);

    typedef enum logic [6:0]
    {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_APPEND = 7'b0000100,
        S_RUN    = 7'b0001000,
        S_WAIT   = 7'b0010000,
        S_FINISH = 7'b0100000,
        S_RESP   = 7'b1000000
    } state_t;

    state_t       state_reg, state_next;
    logic [W-1:0] entry_reg, entry_next;
    logic [W-1:0] held_reg, held_next;
    logic [2:0]   pend_reg, pend_next;
    logic         await_reg, await_next;
    logic         shown_reg, shown_next;
    logic [1:0]   kind_reg, kind_next;
    logic [3:0]   digit_reg, digit_next;
    logic [2:0]   op_reg, op_next;
    logic         acc_reg, acc_next;
    logic         err_reg, err_next;
    logic         neg_reg, neg_next;

    unit_cmd_t    ucmd;
    logic [W-1:0] u_a, u_b, u_result;
    logic         u_done;

    logic signed [63:0] entry_sx;
    logic         fits;
    logic [W-1:0] mag_x, mag_y;
    logic [63:0]  entry_zx;
    state_t       post_state;

    ffck_muldiv #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (ucmd),
        .op_a   (u_a),
        .op_b   (u_b),
        .done   (u_done),
        .result (u_result)
    );

    assign entry_sx   = 64'($signed(entry_reg));
    assign fits       = (MAX_DIGITS > 1) && (entry_sx < LIMIT) && (entry_sx > -LIMIT);
    assign mag_x      = held_reg[W-1] ? (~held_reg + 1'b1) : held_reg;
    assign mag_y      = entry_reg[W-1] ? (~entry_reg + 1'b1) : entry_reg;
    assign post_state = (kind_reg == KIND_OPER) ? S_FINISH : S_RESP;

    always_comb
    begin
        state_next = state_reg;
        entry_next = entry_reg;
        held_next  = held_reg;
        pend_next  = pend_reg;
        await_next = await_reg;
        shown_next = shown_reg;
        kind_next  = kind_reg;
        digit_next = digit_reg;
        op_next    = op_reg;
        acc_next   = acc_reg;
        err_next   = err_reg;
        neg_next   = neg_reg;
        ucmd.start = 1'b0;
        ucmd.mode  = MODE_MUL;
        u_a        = held_reg;
        u_b        = entry_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = req_type;
                    digit_next = digit_value;
                    op_next    = operator_code;
                    acc_next   = 1'b0;
                    err_next   = 1'b0;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_RESP;
                case (kind_reg)
                    KIND_DIGIT:
                    begin
                        if (digit_reg <= DIGIT_MAX)
                        begin
                            if (await_reg)
                            begin
                                entry_next = '0;
                                await_next = 1'b0;
                                acc_next   = 1'b1;
                            end
                            if (shown_reg)
                            begin
                                entry_next = '0;
                                pend_next  = OP_NONE;
                                shown_next = 1'b0;
                                acc_next   = 1'b1;
                            end
                            state_next = S_APPEND;
                        end
                    end
                    KIND_OPER:
                    begin
                        if (op_reg <= OP_DIV && !(pend_reg != OP_NONE && await_reg))
                        begin
                            state_next = (pend_reg != OP_NONE && !shown_reg) ? S_RUN
                                                                             : S_FINISH;
                        end
                    end
                    KIND_EQUALS:
                    begin
                        if (!await_reg && pend_reg != OP_NONE)
                        begin
                            state_next = S_RUN;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_APPEND:
            begin
                if (fits)
                begin
                    entry_next = (entry_reg << 3) + (entry_reg << 1) + W'(digit_reg);
                    acc_next   = 1'b1;
                end
                state_next = S_RESP;
            end
            S_RUN:
            begin
                held_next  = entry_reg;
                shown_next = 1'b1;
                acc_next   = 1'b1;
                state_next = post_state;
                case (pend_reg)
                    OP_ADD:
                    begin
                        entry_next = held_reg + entry_reg;
                    end
                    OP_SUB:
                    begin
                        entry_next = held_reg - entry_reg;
                    end
                    OP_MUL:
                    begin
                        ucmd.start = 1'b1;
                        ucmd.mode  = MODE_MUL;
                        state_next = S_WAIT;
                    end
                    OP_DIV:
                    begin
                        if (entry_reg == '0)
                        begin
                            entry_next = '0;
                            err_next   = 1'b1;
                        end
                        else
                        begin
                            ucmd.start = 1'b1;
                            ucmd.mode  = MODE_DIV;
                            u_a        = mag_y;
                            u_b        = mag_x;
                            neg_next   = held_reg[W-1] ^ entry_reg[W-1];
                            state_next = S_WAIT;
                        end
                    end
                    default:
                    begin
                        entry_next = '0;
                    end
                endcase
            end
            S_WAIT:
            begin
                if (u_done)
                begin
                    if (pend_reg == OP_DIV && neg_reg)
                    begin
                        entry_next = ~u_result + 1'b1;
                    end
                    else
                    begin
                        entry_next = u_result;
                    end
                    state_next = post_state;
                end
            end
            S_FINISH:
            begin
                held_next  = entry_reg;
                await_next = 1'b1;
                shown_next = 1'b0;
                pend_next  = op_reg;
                acc_next   = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            entry_reg <= '0;
            held_reg  <= '0;
            pend_reg  <= OP_NONE;
            await_reg <= 1'b0;
            shown_reg <= 1'b0;
            acc_reg   <= 1'b0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            entry_reg <= entry_next;
            held_reg  <= held_next;
            pend_reg  <= pend_next;
            await_reg <= await_next;
            shown_reg <= shown_next;
            acc_reg   <= acc_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        digit_reg <= digit_next;
        op_reg    <= op_next;
        neg_reg   <= neg_next;
    end

    assign entry_zx      = 64'(entry_reg);
    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = (state_reg == S_RESP);
    assign display_value = $signed(entry_zx[DISPLAY_WIDTH-1:0]);
    assign accepted      = acc_reg;
    assign divide_error  = err_reg;

endmodule
`default_nettype wire

FILE: test/four_function_calculator_keys_core_tb.sv
// ----------------------------------------------------------------------------
// four_function_calculator_keys_core_tb
// Self-checking bench for the calculator keypad event sequencer.
// ----------------------------------------------------------------------------
// A table of directed key presses covers ignored keys, the digit limit,
// divide by zero and each operator. A weighted random stream of digits,
// operators and equals follows. Each result is checked against the table
// where it gives a value, else against a behavioral calculator kept in step
// with the accepted keys. Both sides idle at random; the receiver holds off
// once for a long stretch and the sender pauses once until the block drains.
// ----------------------------------------------------------------------------
module four_function_calculator_keys_core_tb;

    import ffck_pkg::*;

    localparam int         RANDOM_KEYS    = 1620;
    localparam int         NUM_DIRECTED   = 27;
    localparam int         IDLE_LIMIT     = 2000;
    localparam int         DRAIN_CYCLES   = 60;
    localparam int         LONG_HOLD      = 400;
    localparam logic [1:0] KIND_RESERVED  = 2'd3;
    localparam logic [2:0] OP_UNUSED      = 3'd7;

    typedef struct packed
    {
        logic signed [31:0] disp;
        logic               acc;
        logic               err;
    } key_result_t;

    typedef struct packed
    {
        logic [1:0]  kind;
        logic [3:0]  digit;
        logic [2:0]  oper;
        logic        known;
        key_result_t result;
    } key_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic [3:0]  digit_value;
    logic [2:0]  operator_code;
    logic        out_valid;
    logic        out_stall;
    logic signed [DISPLAY_WIDTH-1:0] display_value;
    logic        accepted;
    logic        divide_error;

    logic [31:0] calc_entry;
    logic [31:0] calc_held;
    logic [2:0]  calc_pending;
    logic        calc_awaiting;
    logic        calc_shown;

    key_result_t calc_results_q[$];
    key_row_t    directed_keys [0:NUM_DIRECTED-1];

    int fail_count   = 0;
    int keys_sent    = 0;
    int results_seen = 0;
    int ops_run      = 0;
    int div_zeros    = 0;
    int idle_cycles  = 0;
    bit sender_calm  = 0;
    bit sink_calm    = 0;

    four_function_calculator_keys_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .digit_value   (digit_value),
        .operator_code (operator_code),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .display_value (display_value),
        .accepted      (accepted),
        .divide_error  (divide_error)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic [31:0] abs_value(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic int digit_count(input logic [31:0] v);
        logic [31:0] m;
        int          n;
        m = abs_value(v);
        n = 0;
        do
        begin
            m = m / 32'd10;
            n++;
        end
        while (m != 0);
        return n;
    endfunction

    function automatic logic evaluate_pending(output logic div_zero);
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] r;
        logic [31:0] q;
        div_zero = 1'b0;
        x = calc_held;
        y = calc_entry;
        r = '0;
        if (calc_awaiting || calc_pending == OP_NONE)
        begin
            return 1'b0;
        end
        case (calc_pending)
            OP_ADD: r = x + y;
            OP_SUB: r = x - y;
            OP_MUL: r = x * y;
            OP_DIV:
            begin
                if (y == 0)
                begin
                    r = '0;
                    div_zero = 1'b1;
                end
                else
                begin
                    q = abs_value(x) / abs_value(y);
                    r = (x[31] ^ y[31]) ? (32'd0 - q) : q;
                end
            end
            default: r = '0;
        endcase
        calc_entry = r;
        calc_held  = y;
        calc_shown = 1'b1;
        ops_run++;
        if (div_zero)
        begin
            div_zeros++;
        end
        return 1'b1;
    endfunction

    function automatic key_result_t press_key(input logic [1:0] kind,
                                              input logic [3:0] dig,
                                              input logic [2:0] oper);
        key_result_t res;
        logic        acc;
        logic        derr;
        acc  = 1'b0;
        derr = 1'b0;
        case (kind)
            KIND_DIGIT:
            begin
                if (dig <= DIGIT_MAX)
                begin
                    if (calc_awaiting)
                    begin
                        calc_entry    = '0;
                        calc_awaiting = 1'b0;
                        acc           = 1'b1;
                    end
                    if (calc_shown)
                    begin
                        calc_entry   = '0;
                        calc_pending = OP_NONE;
                        calc_shown   = 1'b0;
                        acc          = 1'b1;
                    end
                    if (digit_count(calc_entry) < MAX_DIGITS_DEFAULT)
                    begin
                        calc_entry = calc_entry * 32'd10 + {28'd0, dig};
                        acc        = 1'b1;
                    end
                end
            end
            KIND_OPER:
            begin
                if (oper <= OP_DIV && !(calc_pending != OP_NONE && calc_awaiting))
                begin
                    if (calc_pending != OP_NONE && !calc_shown)
                    begin
                        void'(evaluate_pending(derr));
                    end
                    calc_held     = calc_entry;
                    calc_awaiting = 1'b1;
                    calc_shown    = 1'b0;
                    calc_pending  = oper;
                    acc           = 1'b1;
                end
            end
            KIND_EQUALS:
            begin
                acc = evaluate_pending(derr);
            end
            default:
            begin
            end
        endcase
        res.disp = calc_entry;
        res.acc  = acc;
        res.err  = derr;
        return res;
    endfunction

    task automatic send_key(input logic [1:0] kind, input logic [3:0] dig,
                            input logic [2:0] oper, input logic known,
                            input key_result_t typed_result,
                            output logic was_accepted);
        int          gap;
        key_result_t got;
        gap = sender_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= kind;
        digit_value   <= dig;
        operator_code <= oper;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        got = press_key(kind, dig, oper);
        calc_results_q.push_back(known ? typed_result : got);
        was_accepted = got.acc;
        keys_sent++;
        if (keys_sent % 50 == 0)
        begin
            sender_calm = ($urandom_range(0, 3) == 0);
        end
    endtask

    initial
    begin
        directed_keys = '{
            '{KIND_EQUALS,   4'd0,  OP_NONE,   1'b1, '{32'sd0, 1'b0, 1'b0}},
            '{KIND_DIGIT,    4'd15, OP_NONE,   1'b1, '{32'sd0, 1'b0, 1'b0}},
            '{KIND_RESERVED, 4'd0,  OP_UNUSED, 1'b1, '{32'sd0, 1'b0, 1'b0}},
            '{KIND_OPER,     4'd0,  OP_UNUSED, 1'b1, '{32'sd0, 1'b0, 1'b0}},
            '{KIND_OPER,     4'd0,  OP_NONE,   1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{KIND_DIGIT,    4'd9,  OP_NONE,   1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{KIND_DIGIT,    4'd9,  OP_NONE,   1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{KIND_DIGIT,    4'd9,  OP_NONE,   1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{KIND_DIGIT,    4'd9,  OP_NONE,   1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{KIND_DIGIT,    4'd9,  OP_NONE,   1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{KIND_DIGIT,    4'd9,  OP_NONE,   1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{KIND_DIGIT,    4'd9,  OP_NONE,   1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{KIND_DIGIT,    4'd9,  OP_NONE,   1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{KIND_DIGIT,    4'd9,  OP_NONE,   1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{KIND_DIGIT,    4'd9,  OP_NONE,   1'b1, '{32'sd999999999, 1'b0, 1'b0}},
            '{KIND_OPER,     4'd0,  OP_DIV,    1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{KIND_DIGIT,    4'd0,  OP_NONE,   1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{KIND_EQUALS,   4'd0,  OP_NONE,   1'b1, '{32'sd0, 1'b1, 1'b1}},
            '{KIND_OPER,     4'd0,  OP_SUB,    1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{KIND_OPER,     4'd0,  OP_MUL,    1'b1, '{32'sd0, 1'b0, 1'b0}},
            '{KIND_DIGIT,    4'd7,  OP_NONE,   1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{KIND_OPER,     4'd0,  OP_ADD,    1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{KIND_DIGIT,    4'd8,  OP_NONE,   1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{KIND_EQUALS,   4'd0,  OP_NONE,   1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{KIND_OPER,     4'd0,  OP_MUL,    1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{KIND_DIGIT,    4'd3,  OP_NONE,   1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{KIND_EQUALS,   4'd0,  OP_NONE,   1'b0, '{32'sd0, 1'b0, 1'b0}}
        };
    end

    initial
    begin
        logic [1:0] kind;
        logic [3:0] dig;
        logic [2:0] oper;
        logic       acc;
        int         useful_keys;
        int         burst_left;
        int         w;
        in_valid      = 1'b0;
        req_type      = KIND_DIGIT;
        digit_value   = 4'd0;
        operator_code = OP_NONE;
        rst_n         = 1'b0;
        calc_entry    = '0;
        calc_held     = '0;
        calc_pending  = OP_NONE;
        calc_awaiting = 1'b0;
        calc_shown    = 1'b0;
        useful_keys   = 0;
        burst_left    = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            send_key(directed_keys[i].kind, directed_keys[i].digit, directed_keys[i].oper,
                     directed_keys[i].known, directed_keys[i].result, acc);
        end

        while (keys_sent < NUM_DIRECTED + RANDOM_KEYS)
        begin
            dig  = 4'($urandom_range(0, 15));
            oper = 3'($urandom_range(0, 7));
            w    = $urandom_range(0, 99);
            if (burst_left == 0 && w < 4)
            begin
                burst_left = $urandom_range(5, 11);
            end
            if (burst_left > 0)
            begin
                kind = KIND_DIGIT;
                dig  = 4'($urandom_range(0, 9));
                burst_left--;
            end
            else if (w < 45)
            begin
                kind = KIND_DIGIT;
                dig  = 4'($urandom_range(0, 9));
            end
            else if (w < 65)
            begin
                kind = KIND_OPER;
                oper = ($urandom_range(0, 9) == 0) ? OP_NONE : 3'($urandom_range(1, 4));
            end
            else if (w < 82)
            begin
                kind = KIND_EQUALS;
            end
            else
            begin
                kind = 2'($urandom_range(0, 3));
            end
            send_key(kind, dig, oper, 1'b0, '0, acc);
            if (acc)
            begin
                useful_keys++;
            end
            // drain the block once with the sender held back
            if (keys_sent == NUM_DIRECTED + RANDOM_KEYS / 2)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (calc_results_q.size() != 0)
                begin
                    @(posedge clk);
                end
            end
        end
        in_valid <= 1'b0;

        while (calc_results_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d keypad events (%0d random ones took effect), checked %0d results.",
                 keys_sent, useful_keys, results_seen);
        $display("Evaluated %0d operations, %0d of them divide by zero.",
                 ops_run, div_zeros);
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        int  hold;
        int  taken;
        bit  long_done;
        out_stall = 1'b0;
        taken     = 0;
        long_done = 0;
        @(posedge rst_n);
        forever
        begin
            if (!long_done && results_seen >= 300)
            begin
                hold      = LONG_HOLD;
                long_done = 1;
            end
            else
            begin
                hold = sink_calm ? 0 : $urandom_range(0, 11);
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
            begin
                @(posedge clk);
            end
            while (!(out_valid && !out_stall));
            taken++;
            if (taken % 50 == 0)
            begin
                sink_calm = ($urandom_range(0, 3) == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        key_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (calc_results_q.size() == 0)
            begin
                $error("unexpected transaction: display_value %0d accepted %0b divide_error %0b",
                       display_value, accepted, divide_error);
                fail_count++;
            end
            else
            begin
                want = calc_results_q.pop_front();
                if (display_value !== want.disp)
                begin
                    $error("display_value: expected %0d, got %0d", want.disp, display_value);
                    fail_count++;
                end
                if (accepted !== want.acc)
                begin
                    $error("accepted: expected %0b, got %0b", want.acc, accepted);
                    fail_count++;
                end
                if (divide_error !== want.err)
                begin
                    $error("divide_error: expected %0b, got %0b", want.err, divide_error);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("No transaction for %0d cycles; %0d results outstanding.",
                         idle_cycles, calc_results_q.size());
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule

FILE: four_function_calculator_keys_core.f
hw/rtl/ffck_pkg.sv
hw/rtl/ffck_muldiv.sv
hw/rtl/four_function_calculator_keys_core.sv
test/four_function_calculator_keys_core_tb.sv
